/* src/ddtc_pkg.sv */
package ddtc_pkg;

	// Sequencer states of the top level
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CORDIC,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_MODE,
		ST_MUL_SLOW,
		ST_DIV_SLOW_GO,
		ST_DIV_SLOW,
		ST_MUL_FAST,
		ST_DIV_FAST_GO,
		ST_DIV_FAST,
		ST_OUT
	} state_t;

	// Turning mode codes
	typedef enum logic [1:0] {
		MODE_STRAIGHT = 2'd0,
		MODE_SOFT     = 2'd1,
		MODE_HARD     = 2'd2
	} mode_t;

	// Register indexes on the configuration port
	localparam logic [1:0] REG_SPEED_LIM = 2'd0;
	localparam logic [1:0] REG_HARD_THR  = 2'd1;
	localparam logic [1:0] REG_SOFT_THR  = 2'd2;
	localparam logic [1:0] REG_STRAIGHT  = 2'd3;

	localparam logic [14:0] SPEED_LIM_RST = 15'd2560;
	localparam logic [14:0] HARD_THR_RST  = 15'd16384;
	localparam logic [14:0] SOFT_THR_RST  = 15'd12743;
	localparam logic [14:0] STRAIGHT_RST  = 15'd1820;

	// Inverse CORDIC gain, Q30
	localparam logic [29:0] INV_GAIN = 30'd652032875;

	// Quotient bits of the soft-turn divider
	localparam int DIV_BITS = 15;

	// Widths of the CORDIC datapath
	localparam int XY_W = 36;
	localparam int Z_W  = 34;

	// atan(2^-i)/pi * 2^31, truncated
	function automatic logic [29:0] atan_lut(input logic [4:0] idx);
		logic [29:0] v;
		case (idx)
			5'd0:  v = 30'd536870912;
			5'd1:  v = 30'd316933406;
			5'd2:  v = 30'd167458907;
			5'd3:  v = 30'd85004756;
			5'd4:  v = 30'd42667331;
			5'd5:  v = 30'd21354465;
			5'd6:  v = 30'd10679838;
			5'd7:  v = 30'd5340245;
			5'd8:  v = 30'd2670163;
			5'd9:  v = 30'd1335086;
			5'd10: v = 30'd667544;
			5'd11: v = 30'd333772;
			5'd12: v = 30'd166886;
			5'd13: v = 30'd83443;
			5'd14: v = 30'd41721;
			5'd15: v = 30'd20860;
			5'd16: v = 30'd10430;
			5'd17: v = 30'd5215;
			5'd18: v = 30'd2607;
			5'd19: v = 30'd1303;
			5'd20: v = 30'd651;
			5'd21: v = 30'd325;
			5'd22: v = 30'd162;
			5'd23: v = 30'd81;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

/* src/ddtc_cordic.sv */
module ddtc_cordic
	import ddtc_pkg::*;
#(
	parameter int STEPS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic signed [15:0]     x_in,
	input  logic signed [15:0]     y_in,
	output logic                   done,
	output logic signed [XY_W-1:0] x_out,
	output logic signed [Z_W-1:0]  z_out
);

	localparam int IW = $clog2(STEPS);

	logic signed [XY_W-1:0] x_q, y_q;
	logic signed [Z_W-1:0]  z_q;
	logic [IW-1:0]          i_q;
	logic                   run_q, done_q;

	logic signed [XY_W-1:0] x0, y0, dx, dy;
	logic signed [Z_W-1:0]  rot;
	logic                   last;

	assign x0   = {{(XY_W-32){x_in[15]}}, x_in, 16'b0};
	assign y0   = {{(XY_W-32){y_in[15]}}, y_in, 16'b0};
	assign dx   = y_q >>> i_q;
	assign dy   = x_q >>> i_q;
	assign rot  = $signed({{(Z_W-30){1'b0}}, atan_lut(5'(i_q))});
	assign last = (i_q == IW'(STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= run_q && last;
			if (start) begin
				run_q <= 1'b1;
				i_q   <= '0;
			end else if (run_q) begin
				if (last) begin
					run_q <= 1'b0;
				end
				i_q <= i_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// pre-rotate a left half-plane vector by a quarter turn
			if (x_in[15]) begin
				if (y_in > 16'sd0) begin
					x_q <= y0;
					y_q <= -x0;
					z_q <= Z_W'(34'sd1073741824);
				end else begin
					x_q <= -y0;
					y_q <= x0;
					z_q <= -Z_W'(34'sd1073741824);
				end
			end else begin
				x_q <= x0;
				y_q <= y0;
				z_q <= '0;
			end
		end else if (run_q) begin
			if (y_q > 0) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + rot;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - rot;
			end
		end
	end

	assign done  = done_q;
	assign x_out = x_q;
	assign z_out = z_q;

endmodule

/* src/ddtc_div.sv */
module ddtc_div
	import ddtc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [31:0]         num,
	input  logic [DIV_BITS-1:0] den,
	output logic                done,
	output logic [DIV_BITS-1:0] quo
);

	localparam int CW = $clog2(DIV_BITS + 1);

	logic [CW-1:0]       cnt_q;
	logic                done_q, sat_q;
	logic [DIV_BITS-1:0] r_q, n_q, q_q, den_q;
	logic [DIV_BITS:0]   trial;
	logic                fits;

	assign trial = {r_q, n_q[DIV_BITS-1]};
	assign fits  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CW'(1));
			if (start) begin
				cnt_q <= CW'(DIV_BITS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// quotient at or above full scale saturates
			sat_q <= (num[31:DIV_BITS] >= {{(32-2*DIV_BITS){1'b0}}, den});
			r_q   <= num[2*DIV_BITS-1:DIV_BITS];
			n_q   <= num[DIV_BITS-1:0];
			q_q   <= '0;
			den_q <= den;
		end else if (cnt_q != '0) begin
			r_q <= fits ? DIV_BITS'(trial - {1'b0, den_q}) : trial[DIV_BITS-1:0];
			q_q <= {q_q[DIV_BITS-2:0], fits};
			n_q <= {n_q[DIV_BITS-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign quo  = sat_q ? {DIV_BITS{1'b1}} : q_q;

endmodule

/* src/differential_drive_turn_controller_top.sv */
// Differential-drive turn controller.
// Heading channel (heading_valid/heading_ready) takes one word: the desired
// heading vector heading_x, heading_y in signed Q8.8. Speed channel
// (speed_valid/speed_ready) returns one word per heading: left_speed,
// right_speed (signed Q8.8, saturated) and turn_mode (0 straight, 1 soft,
// 2 hard). The APB port holds the wheel speed limit and the three angle
// thresholds at byte addresses 0, 4, 8 and 12; pready is always high.
// One heading at a time: heading_ready is high only while the sequencer
// idles. A vectoring CORDIC runs one micro-rotation per cycle, one shared
// 18x30 multiplier forms the length in a low and a high half and the
// soft-turn products, and a restoring divider yields one quotient bit per
// cycle, used twice. A heading on the x axis skips the CORDIC. The next
// heading is taken the cycle after the word loads. The finished word sits
// in an output register, so the next heading is taken while it waits; if
// the receiver stalls until the following word is done, the sequencer
// holds that word until the register frees.
// Reset clears the mode to straight, loads the register defaults and drops
// any pending word.
module differential_drive_turn_controller_top
	import ddtc_pkg::*;
#(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               heading_valid,
	output logic               heading_ready,
	input  logic signed [15:0] heading_x,
	input  logic signed [15:0] heading_y,
	output logic               speed_valid,
	input  logic               speed_ready,
	output logic signed [15:0] left_speed,
	output logic signed [15:0] right_speed,
	output logic [1:0]         turn_mode,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	state_t state_q, state_nxt;
	mode_t  mode_q, mode_nxt;

	// configuration registers
	logic [14:0] speed_lim_q, hard_q, soft_q, straight_q;

	// working registers
	logic signed [16:0] ang_q;
	logic [19:0]        len_q;
	logic [14:0]        base_q;
	logic [65:0]        acc_q;
	logic [31:0]        numer_q;
	logic signed [15:0] slow_q, fast_q;
	logic               out_valid_q;
	logic signed [15:0] left_q, right_q;
	logic [1:0]         turn_q;

	logic                   accept, cordic_start, cordic_done;
	logic signed [XY_W-1:0] cordic_x;
	logic signed [Z_W-1:0]  cordic_z;
	logic                   div_start, div_done;
	logic [DIV_BITS-1:0]    div_quo;
	logic                   out_load;

	logic [34:0]        x_pos;
	logic signed [Z_W-1:0] z_round;
	logic signed [17:0] ang_raw;
	logic signed [16:0] ang_cordic, ang_neg;
	logic [15:0]        mag;
	logic [14:0]        h_eff, num_slow, base_nxt;
	logic [15:0]        num_fast;
	logic [17:0]        mul_a;
	logic [29:0]        mul_b;
	logic [47:0]        prod;
	logic [65:0]        len_sum;
	logic signed [15:0] abs_x;

	assign accept       = heading_valid && heading_ready;
	assign cordic_start = accept && (heading_y != 16'sd0);

	ddtc_cordic #(
		.STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cordic_start),
		.x_in  (heading_x),
		.y_in  (heading_y),
		.done  (cordic_done),
		.x_out (cordic_x),
		.z_out (cordic_z)
	);

	ddtc_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (numer_q),
		.den   (h_eff),
		.done  (div_done),
		.quo   (div_quo)
	);

	// APB register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_lim_q <= SPEED_LIM_RST;
			hard_q      <= HARD_THR_RST;
			soft_q      <= SOFT_THR_RST;
			straight_q  <= STRAIGHT_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_SPEED_LIM: speed_lim_q <= pwdata[14:0];
				REG_HARD_THR:  hard_q      <= pwdata[14:0];
				REG_SOFT_THR:  soft_q      <= pwdata[14:0];
				REG_STRAIGHT:  straight_q  <= pwdata[14:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_SPEED_LIM: prdata = {17'b0, speed_lim_q};
			REG_HARD_THR:  prdata = {17'b0, hard_q};
			REG_SOFT_THR:  prdata = {17'b0, soft_q};
			REG_STRAIGHT:  prdata = {17'b0, straight_q};
		endcase
	end

	assign pready = 1'b1;

	// angle: round the accumulator to binary units and fold -pi onto +pi
	assign z_round = cordic_z + Z_W'(34'sd32768);
	assign ang_raw = z_round[Z_W-1:16];
	assign ang_cordic = (ang_raw > 18'sd32768 || ang_raw <= -18'sd32768) ?
		17'sd32768 : ang_raw[16:0];
	assign ang_neg = -ang_q;
	assign mag     = ang_q[16] ? ang_neg[15:0] : ang_q[15:0];
	assign abs_x   = heading_x[15] ? -heading_x : heading_x;

	assign x_pos = cordic_x[XY_W-1] ? '0 : cordic_x[34:0];

	assign base_nxt = (len_q < {5'b0, speed_lim_q}) ? len_q[14:0] : speed_lim_q;
	assign h_eff    = (hard_q == '0) ? 15'd1 : hard_q;
	assign num_slow = ({1'b0, mag} <= {1'b0, h_eff}) ? 15'(h_eff - mag[14:0]) : '0;
	assign num_fast = {1'b0, h_eff} + mag;

	// shared multiplier
	assign prod    = mul_a * mul_b;
	assign len_sum = acc_q + ({18'b0, prod} << 18);

	// mode update: test hard, then soft, then straight
	always_comb begin
		mode_nxt = mode_q;
		if (mode_nxt == MODE_HARD && mag <= {1'b0, soft_q}) begin
			mode_nxt = MODE_SOFT;
		end
		if (mode_nxt == MODE_SOFT) begin
			if (mag > {1'b0, hard_q}) begin
				mode_nxt = MODE_HARD;
			end else if (mag <= {1'b0, straight_q}) begin
				mode_nxt = MODE_STRAIGHT;
			end
		end
		if (mode_nxt == MODE_STRAIGHT) begin
			if (mag > {1'b0, hard_q}) begin
				mode_nxt = MODE_HARD;
			end else if (mag > {1'b0, straight_q}) begin
				mode_nxt = MODE_SOFT;
			end
		end
	end

	// sequencer: next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_nxt = (heading_y != 16'sd0) ? ST_CORDIC : ST_MODE;
				end
			end
			ST_CORDIC: begin
				if (cordic_done) begin
					state_nxt = ST_MUL_LO;
				end
			end
			ST_MUL_LO:      state_nxt = ST_MUL_HI;
			ST_MUL_HI:      state_nxt = ST_MODE;
			ST_MODE:        state_nxt = (mode_nxt == MODE_SOFT) ? ST_MUL_SLOW : ST_OUT;
			ST_MUL_SLOW:    state_nxt = ST_DIV_SLOW_GO;
			ST_DIV_SLOW_GO: state_nxt = ST_DIV_SLOW;
			ST_DIV_SLOW: begin
				if (div_done) begin
					state_nxt = ST_MUL_FAST;
				end
			end
			ST_MUL_FAST:    state_nxt = ST_DIV_FAST_GO;
			ST_DIV_FAST_GO: state_nxt = ST_DIV_FAST;
			ST_DIV_FAST: begin
				if (div_done) begin
					state_nxt = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_load) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// sequencer: outputs
	always_comb begin
		heading_ready = 1'b0;
		div_start     = 1'b0;
		out_load      = 1'b0;
		mul_a         = '0;
		mul_b         = '0;
		unique case (state_q)
			ST_IDLE:        heading_ready = 1'b1;
			ST_MUL_LO: begin
				mul_a = x_pos[17:0];
				mul_b = INV_GAIN;
			end
			ST_MUL_HI: begin
				mul_a = {1'b0, x_pos[34:18]};
				mul_b = INV_GAIN;
			end
			ST_MUL_SLOW: begin
				mul_a = {3'b0, num_slow};
				mul_b = {15'b0, base_q};
			end
			ST_MUL_FAST: begin
				mul_a = {2'b0, num_fast};
				mul_b = {15'b0, base_q};
			end
			ST_DIV_SLOW_GO: div_start = 1'b1;
			ST_DIV_FAST_GO: div_start = 1'b1;
			ST_OUT:         out_load  = !out_valid_q || speed_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_STRAIGHT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_MODE) begin
				mode_q <= mode_nxt;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (speed_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			// on the x axis the angle and length are exact
			ang_q <= heading_x[15] ? 17'sd32768 : 17'sd0;
			len_q <= {4'b0, abs_x[15] ? 16'h8000 : abs_x};
		end
		if (state_q == ST_MUL_LO) begin
			ang_q <= ang_cordic;
			acc_q <= {18'b0, prod} + (66'd1 << 45);
		end
		if (state_q == ST_MUL_HI) begin
			len_q <= len_sum[65:46];
		end
		if (state_q == ST_MODE) begin
			base_q <= base_nxt;
			if (mode_nxt == MODE_HARD) begin
				slow_q <= -$signed({1'b0, speed_lim_q});
				fast_q <= $signed({1'b0, speed_lim_q});
			end else begin
				slow_q <= $signed({1'b0, base_nxt});
				fast_q <= $signed({1'b0, base_nxt});
			end
		end
		if (state_q == ST_MUL_SLOW || state_q == ST_MUL_FAST) begin
			numer_q <= prod[31:0] + {18'b0, h_eff[14:1]};
		end
		if (state_q == ST_DIV_SLOW && div_done) begin
			slow_q <= $signed({1'b0, div_quo});
		end
		if (state_q == ST_DIV_FAST && div_done) begin
			fast_q <= $signed({1'b0, div_quo});
		end
		if (out_load) begin
			// a left turn slows the left wheel
			if (ang_q > 17'sd0) begin
				left_q  <= slow_q;
				right_q <= fast_q;
			end else begin
				left_q  <= fast_q;
				right_q <= slow_q;
			end
			turn_q <= mode_q;
		end
	end

	assign speed_valid = out_valid_q;
	assign left_speed  = left_q;
	assign right_speed = right_q;
	assign turn_mode   = turn_q;

endmodule

/* dv/ddtc_speed_checker.sv */
module ddtc_speed_checker
	import ddtc_pkg::*;
#(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               heading_valid,
	input  logic               heading_ready,
	input  logic signed [15:0] heading_x,
	input  logic signed [15:0] heading_y,
	input  logic               speed_valid,
	input  logic               speed_ready,
	input  logic signed [15:0] left_speed,
	input  logic signed [15:0] right_speed,
	input  logic [1:0]         turn_mode,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	output int                 mismatches,
	output int                 words_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [15:0] left_spd;
		logic signed [15:0] right_spd;
		mode_t              mode;
	} speed_word_t;

	localparam longint unsigned INV_GAIN_Q30 = 64'd652032875;

	// atan(2^-i) in binary-angle units scaled by 2^16
	longint atan_bam16 [24] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335086, 667544, 333772,
		166886, 83443, 41721, 20860, 10430, 5215,
		2607, 1303, 651, 325, 162, 81
	};

	logic [14:0] max_spd;
	logic [14:0] hard_thr;
	logic [14:0] soft_thr;
	logic [14:0] straight_thr;
	mode_t       turn_state;
	speed_word_t speeds_due [$];
	int          errs = 0;

	// Work out wheel speeds for one heading and advance the kept turning mode
	function automatic speed_word_t predict_speeds(input logic signed [15:0] hx,
			input logic signed [15:0] hy);
		longint x, y, cx, cy, z, t, dx, dy, a, ang;
		longint unsigned len, mag, base, h, s1, s2, num1;
		longint slow, fast;
		speed_word_t w;
		x = hx;
		y = hy;
		if (y == 0) begin
			ang = (x < 0) ? 32768 : 0;
			len = (x < 0) ? -x : x;
		end else begin
			cx = x * 65536;
			cy = y * 65536;
			z = 0;
			// left half-plane: pre-rotate by a quarter turn
			if (cx < 0) begin
				t = cx;
				if (cy > 0) begin
					cx = cy;
					cy = -t;
					z = 64'sd16384 * 65536;
				end else begin
					cx = -cy;
					cy = t;
					z = -64'sd16384 * 65536;
				end
			end
			for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
				dx = cy >>> i;
				dy = cx >>> i;
				if (cy > 0) begin
					cx += dx;
					cy -= dy;
					z += atan_bam16[i];
				end else begin
					cx -= dx;
					cy += dy;
					z -= atan_bam16[i];
				end
			end
			a = (z + 32768) >>> 16;
			if (a > 32768) a = 32768;
			if (a <= -32768) a = 32768;
			ang = a;
			if (cx < 0) cx = 0;
			len = (unsigned'(cx) * INV_GAIN_Q30 + (64'd1 << 45)) >> 46;
		end
		mag = (ang < 0) ? -ang : ang;
		base = (len < max_spd) ? len : max_spd;

		// hysteresis: hard rule first, then soft, then straight
		if (turn_state == MODE_HARD && mag <= soft_thr) turn_state = MODE_SOFT;
		if (turn_state == MODE_SOFT) begin
			if (mag > hard_thr) turn_state = MODE_HARD;
			else if (mag <= straight_thr) turn_state = MODE_STRAIGHT;
		end
		if (turn_state == MODE_STRAIGHT) begin
			if (mag > hard_thr) turn_state = MODE_HARD;
			else if (mag > straight_thr) turn_state = MODE_SOFT;
		end

		if (turn_state == MODE_HARD) begin
			slow = -longint'(max_spd);
			fast = longint'(max_spd);
		end else if (turn_state == MODE_SOFT) begin
			h = (hard_thr != 0) ? hard_thr : 1;
			num1 = (mag <= h) ? h - mag : 0;
			s1 = (base * num1 + h / 2) / h;
			s2 = (base * (h + mag) + h / 2) / h;
			if (s1 > 32767) s1 = 32767;
			if (s2 > 32767) s2 = 32767;
			slow = s1;
			fast = s2;
		end else begin
			slow = base;
			fast = base;
		end

		if (ang > 0) begin
			w.left_spd = slow[15:0];
			w.right_spd = fast[15:0];
		end else begin
			w.left_spd = fast[15:0];
			w.right_spd = slow[15:0];
		end
		w.mode = turn_state;
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		speed_word_t want;
		if (!arst_n) begin
			max_spd = SPEED_LIM_RST;
			hard_thr = HARD_THR_RST;
			soft_thr = SOFT_THR_RST;
			straight_thr = STRAIGHT_RST;
			turn_state = MODE_STRAIGHT;
			speeds_due.delete();
		end else begin
			// compare before pushing, so a word taken this edge never meets its own result
			if (speed_valid && speed_ready) begin
				if (speeds_due.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("%0t: unexpected speed word L=%0d R=%0d mode=%0d",
							$realtime, left_speed, right_speed, turn_mode);
				end else begin
					want = speeds_due.pop_front();
					if (want.left_spd !== left_speed || want.right_spd !== right_speed ||
							want.mode !== turn_mode) begin
						errs++;
						if (errs <= 10)
							$display("%0t: want L=%0d R=%0d m=%0d, got L=%0d R=%0d m=%0d",
								$realtime, want.left_spd, want.right_spd, want.mode,
								left_speed, right_speed, turn_mode);
					end
				end
			end
			if (heading_valid && heading_ready)
				speeds_due.push_back(predict_speeds(heading_x, heading_y));
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_SPEED_LIM: max_spd = pwdata[14:0];
					REG_HARD_THR:  hard_thr = pwdata[14:0];
					REG_SOFT_THR:  soft_thr = pwdata[14:0];
					REG_STRAIGHT:  straight_thr = pwdata[14:0];
					default: ;
				endcase
			end
		end
		mismatches <= errs;
		words_owed <= speeds_due.size();
	end

endmodule

/* dv/testbench.sv */
module testbench
	import ddtc_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STEPS = 16;
	// settle wait after the final drain, to catch stray results
	localparam int SETTLE_CYCLES = 2 * (STEPS + 41);
	// cycles without any word moving before the run is declared hung
	localparam int QUIET_LIMIT = 5000;
	localparam int ITEMS_PER_SETTING = 243;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               heading_valid = 1'b0;
	logic               heading_ready;
	logic signed [15:0] heading_x = '0;
	logic signed [15:0] heading_y = '0;
	logic               speed_valid;
	logic               speed_ready = 1'b0;
	logic signed [15:0] left_speed;
	logic signed [15:0] right_speed;
	logic [1:0]         turn_mode;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [3:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	int                 mismatches;
	int                 words_owed;

	// idle odds in percent for each side, changed per phase
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int quiet_cycles = 0;
	// heading angle that drifts from word to word, to sweep the hysteresis bands
	int walk_bam = 0;
	// thresholds currently in force, used to aim headings at the band edges
	int cur_hard = HARD_THR_RST;
	int cur_soft = SOFT_THR_RST;
	int cur_str = STRAIGHT_RST;

	differential_drive_turn_controller_top #(.CORDIC_STEPS(STEPS)) u_dut (.*);

	ddtc_speed_checker #(.CORDIC_STEPS(STEPS)) u_speed_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: drop ready at random, at the rate the current phase asks
	always @(posedge clk)
		speed_ready <= (int'($urandom_range(99)) >= recv_idle_pct);

	// Watchdog: count edges at which no word moves on any port
	always @(posedge clk) begin
		if ((heading_valid && heading_ready) || (speed_valid && speed_ready) ||
				(psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Build a heading from a binary angle and a length, clipped to the Q8.8 range
	function automatic logic [31:0] polar_heading(input int bam, input int radius);
		real th, fx, fy;
		th = bam * 3.14159265358979 / 32768.0;
		fx = radius * $cos(th);
		fy = radius * $sin(th);
		if (fx > 32767.0) fx = 32767.0;
		if (fx < -32768.0) fx = -32768.0;
		if (fy > 32767.0) fy = 32767.0;
		if (fy < -32768.0) fy = -32768.0;
		return {16'($rtoi(fx)), 16'($rtoi(fy))};
	endfunction

	// Offer one heading word and hold it until the block takes it.
	// Call at a rising edge; returns at the edge that accepts the word.
	task automatic send_heading(input logic signed [15:0] hx, input logic signed [15:0] hy);
		while (int'($urandom_range(99)) < send_idle_pct) begin
			heading_valid <= 1'b0;
			@(posedge clk);
		end
		heading_valid <= 1'b1;
		heading_x <= hx;
		heading_y <= hy;
		@(posedge clk);
		while (!heading_ready) @(posedge clk);
	endtask

	// Drop valid and wait until every predicted speed word has been taken
	task automatic drain_speeds();
		heading_valid <= 1'b0;
		@(posedge clk);
		while (words_owed != 0) @(posedge clk);
	endtask

	// Setup then access phase, then back to idle; junk in the upper data bits
	// must be ignored
	task automatic write_reg(input logic [1:0] idx, input logic [14:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {17'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Mix of drifting headings, headings aimed at a threshold, raw noise,
	// axis and corner vectors, and tiny vectors
	task automatic random_heading(output logic signed [15:0] hx,
			output logic signed [15:0] hy);
		int pick, radius, edge_bam;
		pick = $urandom_range(99);
		radius = ($urandom_range(3) == 0) ? int'($urandom_range(46341)) :
			int'($urandom_range(12000, 300));
		if (pick < 40) begin
			walk_bam += int'($urandom_range(6000)) - 3000;
			if (walk_bam > 32767) walk_bam -= 65536;
			if (walk_bam < -32768) walk_bam += 65536;
			{hx, hy} = polar_heading(walk_bam, radius);
		end else if (pick < 60) begin
			case ($urandom_range(2))
				0: edge_bam = cur_hard;
				1: edge_bam = cur_soft;
				default: edge_bam = cur_str;
			endcase
			edge_bam += int'($urandom_range(16)) - 8;
			if ($urandom_range(1)) edge_bam = -edge_bam;
			{hx, hy} = polar_heading(edge_bam, radius);
		end else if (pick < 75) begin
			hx = 16'($urandom);
			hy = 16'($urandom);
		end else if (pick < 85) begin
			case ($urandom_range(3))
				0: begin
					hx = 16'($urandom);
					hy = '0;
				end
				1: begin
					hx = '0;
					hy = 16'($urandom);
				end
				2: begin
					hx = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
					hy = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
				end
				default: begin
					hx = 16'(int'($urandom_range(2)) - 1);
					hy = 16'(int'($urandom_range(2)) - 1);
				end
			endcase
		end else begin
			hx = 16'(int'($urandom_range(600)) - 300);
			hy = 16'(int'($urandom_range(600)) - 300);
		end
	endtask

	// One phase: load the registers while idle, then stream random headings
	task automatic run_phase(input logic [14:0] ms, input logic [14:0] hard,
			input logic [14:0] soft_lim, input logic [14:0] str,
			input int send_pct, input int recv_pct);
		logic signed [15:0] hx, hy;
		drain_speeds();
		write_reg(REG_SPEED_LIM, ms);
		write_reg(REG_HARD_THR, hard);
		write_reg(REG_SOFT_THR, soft_lim);
		write_reg(REG_STRAIGHT, str);
		cur_hard = hard;
		cur_soft = soft_lim;
		cur_str = str;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		repeat (ITEMS_PER_SETTING) begin
			random_heading(hx, hy);
			send_heading(hx, hy);
		end
	endtask

	initial begin
		logic signed [15:0] hx, hy;
		// hold reset at the start, then release it for good
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 21;
		recv_idle_pct = 80;

		// Directed words under the reset register values
		send_heading(16'sd0, 16'sd0);              // zero vector
		send_heading(16'sh7fff, 16'sd0);           // positive x axis
		send_heading(16'sh8000, 16'sd0);           // negative x axis: angle pi
		send_heading(-16'sd1, 16'sd0);
		send_heading(16'sd1, 16'sd0);
		send_heading(16'sd0, 16'sh7fff);           // straight up: soft left at the hard threshold
		send_heading(16'sd0, 16'sh8000);           // straight down: soft right at the hard threshold
		send_heading(16'sh8000, 16'sh8000);        // corners, longest vectors
		send_heading(16'sh7fff, 16'sh7fff);
		send_heading(16'sh8000, 16'sh7fff);
		send_heading(16'sh7fff, 16'sh8000);
		send_heading(16'sh8000, 16'sd1);           // just off the negative axis
		send_heading(16'sh8000, -16'sd1);
		send_heading(16'sd0, 16'sd1);
		send_heading(-16'sd1, 16'sd1);
		send_heading(-16'sd1, -16'sd1);
		send_heading(16'sd1, 16'sd1);
		send_heading(16'sd10000, 16'sd100);        // straight
		send_heading(16'sd10000, 16'sd3000);       // soft left
		send_heading(-16'sd10000, 16'sd5000);      // hard
		send_heading(16'sd10000, 16'sd5000);       // hard relaxes to soft
		send_heading(-16'sd2000, 16'sd10000);      // back to hard
		send_heading(16'sd1000, 16'sd10000);       // above the soft band: stays hard
		send_heading(16'sd10000, -16'sd3000);      // soft right
		send_heading(16'sd10000, 16'sd0);          // back to straight

		// remaining defaults-phase headings
		repeat (ITEMS_PER_SETTING) begin
			random_heading(hx, hy);
			send_heading(hx, hy);
		end

		// sender lightly idle, receiver mostly stalled
		run_phase(15'd32767, 15'd32767, 15'd32767, 15'd32767, 21, 80);
		// the other way round; lowest limits, then soft band above the hard one
		run_phase(15'd0, 15'd1, 15'd0, 15'd0, 80, 21);
		run_phase(15'd12000, 15'd8000, 15'd12000, 15'd2000, 80, 21);
		// no idling from here: zero hard threshold, then random settings
		run_phase(15'd7000, 15'd0, 15'd5000, 15'd3000, 0, 0);
		run_phase(15'($urandom), 15'($urandom_range(32767, 1)), 15'($urandom),
			15'($urandom), 0, 0);
		run_phase(15'($urandom), 15'($urandom_range(32767, 1)), 15'($urandom),
			15'($urandom), 0, 0);

		// let the last words drain, then watch for stray results
		drain_speeds();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && words_owed == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* sim.f */
src/ddtc_pkg.sv
src/ddtc_cordic.sv
src/ddtc_div.sv
src/differential_drive_turn_controller_top.sv
dv/ddtc_speed_checker.sv
dv/testbench.sv
